FILE: src/hplr_pkg.sv
// Shared constants and fixed tables of the head pose linear regressor.
package hplr_pkg;

   // Field widths
   localparam int NUM_W   = 7;
   localparam int COORD_W = 16;
   localparam int ANGLE_W = 16;
   localparam int STAT_W  = 2;

   // Landmark selection
   localparam int NUM_POINTS     = 7;
   localparam int PT_IDX_W       = 3;
   localparam int LANDMARK_COUNT = 68;
   localparam int LM_CNT_W       = 8;

   // Regression vector: centred x, centred y, then the bias term
   localparam int ELEM_COUNT = 2 * NUM_POINTS + 1;
   localparam int ELEM_IDX_W = 4;
   localparam int ANGLES     = 3;
   localparam int ANG_IDX_W  = 2;

   // Arithmetic widths
   localparam int SUM_W     = 19;            // sum of the kept points, 7 * point
   localparam int NUMER_W   = SUM_W + 1;     // signed centred numerator
   localparam int DVD_SHIFT = 17;            // Q16 scale plus one rounding bit
   localparam int QUOT_W    = 25;            // quotient bits, one per division step
   localparam int HI_SHIFT  = QUOT_W - DVD_SHIFT;
   localparam int STEP_W    = 5;
   localparam int NORM_W    = 24;            // Q8.16
   localparam int COEF_W    = 24;            // Q8.16
   localparam int PROD_W    = NORM_W + COEF_W;
   localparam int ACC_W     = 52;            // Q20.32 sum of products

   localparam logic signed [NORM_W-1:0] NORM_MAX = 24'sh7FFFFF;
   localparam logic signed [NORM_W-1:0] NORM_MIN = 24'sh800000;
   localparam logic signed [NORM_W-1:0] ONE_Q16  = 24'sh010000;

   // Result status codes
   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_MISSING = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FLAT    = 2'd2;

   // Landmark numbers kept for the fit: eye corners, nose tip, mouth corners
   localparam logic [NUM_W-1:0] SEL_INDEX [NUM_POINTS] = '{
      7'd36, 7'd39, 7'd42, 7'd45, 7'd30, 7'd48, 7'd54
   };

   // Regression coefficients in Q8.16: one row per vector element, pitch/yaw/roll
   localparam logic signed [COEF_W-1:0] COEF_TABLE [ELEM_COUNT][ANGLES] = '{
      '{  24'sd9161,     24'sd1795870,  24'sd460480  },
      '{ -24'sd162665,   24'sd628742,   24'sd395679  },
      '{  24'sd83494,    24'sd686785,   24'sd406848  },
      '{  24'sd76943,    24'sd1912904,  24'sd109948  },
      '{  24'sd20104,   -24'sd6804734,  24'sd371090  },
      '{  24'sd313697,   24'sd1171299, -24'sd1006784 },
      '{ -24'sd340798,   24'sd609149,  -24'sd737247  },
      '{ -24'sd1649567,  24'sd712042,  -24'sd1932506 },
      '{ -24'sd368687,   24'sd595532,  -24'sd792868  },
      '{ -24'sd340595,  -24'sd540836,   24'sd877953  },
      '{ -24'sd1550864, -24'sd860802,   24'sd1928869 },
      '{  24'sd4406575,  24'sd43706,    24'sd120785  },
      '{ -24'sd185613,   24'sd299062,  -24'sd1041039 },
      '{ -24'sd311262,  -24'sd248679,   24'sd838769  },
      '{ -24'sd1055130,  24'sd96453,    24'sd264727  }
   };

   function automatic logic signed [COEF_W-1:0] coefficient(
      input logic [ELEM_IDX_W-1:0] elem,
      input logic [ANG_IDX_W-1:0]  ang
   );
      logic signed [COEF_W-1:0] value;
      value = '0;
      if (elem < ELEM_IDX_W'(ELEM_COUNT) && ang < ANG_IDX_W'(ANGLES)) begin
         value = COEF_TABLE[elem][ang];
      end
      return value;
   endfunction

endpackage

FILE: src/head_pose_linear_regressor.sv
// Head pose regressor: landmark capture, normalising divider and shared MAC.
//
// An item without the last flag is stored in its transfer cycle. A last item with all
// points present first sums the kept points and checks the y spread, then per vector
// element loads it, runs the divider steps, rounds and does three multiply-accumulates
// (multiply, then accumulate); the bias element skips the divider. A missing point or a
// flat y spread goes straight to the result. One frame is computed at a time. Input ready
// is low while a frame is computed. Synchronous reset clears control and the seen mask.
module head_pose_linear_regressor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [hplr_pkg::NUM_W-1:0]           req_landmark_number,
   input  logic [hplr_pkg::COORD_W-1:0]         req_coord_x,
   input  logic [hplr_pkg::COORD_W-1:0]         req_coord_y,
   input  logic                                 req_last_landmark,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hplr_pkg::ANGLE_W-1:0]  rsp_pitch_angle,
   output logic signed [hplr_pkg::ANGLE_W-1:0]  rsp_yaw_angle,
   output logic signed [hplr_pkg::ANGLE_W-1:0]  rsp_roll_angle,
   output logic [hplr_pkg::STAT_W-1:0]          rsp_pose_status
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SUM    = 9'b000000010,
      ST_SPREAD = 9'b000000100,
      ST_LOAD   = 9'b000001000,
      ST_DIVIDE = 9'b000010000,
      ST_ROUND  = 9'b000100000,
      ST_MUL    = 9'b001000000,
      ST_ACC    = 9'b010000000,
      ST_POST   = 9'b100000000
   } state_type;

   // Round a Q20.32 sum to Q8.8, halves away from zero, and saturate
   function automatic logic signed [hplr_pkg::ANGLE_W-1:0] to_q8_8(
      input logic signed [hplr_pkg::ACC_W-1:0] acc
   );
      logic [hplr_pkg::ACC_W-1:0] mag;
      logic [hplr_pkg::ACC_W:0]   rounded;
      logic [hplr_pkg::ACC_W-24:0] q;
      logic signed [hplr_pkg::ANGLE_W-1:0] value;
      mag     = acc[hplr_pkg::ACC_W-1] ? hplr_pkg::ACC_W'(-acc) : hplr_pkg::ACC_W'(acc);
      rounded = {1'b0, mag} + (hplr_pkg::ACC_W+1)'(1 << 23);
      q       = rounded[hplr_pkg::ACC_W:24];
      if (acc[hplr_pkg::ACC_W-1]) begin
         if (q > (hplr_pkg::ACC_W-23)'(32768)) begin
            value = 16'sh8000;
         end else begin
            value = -$signed(q[hplr_pkg::ANGLE_W-1:0]);
         end
      end else begin
         if (q > (hplr_pkg::ACC_W-23)'(32767)) begin
            value = 16'sh7FFF;
         end else begin
            value = $signed(q[hplr_pkg::ANGLE_W-1:0]);
         end
      end
      return value;
   endfunction

   state_type state_ff, state_in;

   logic [hplr_pkg::COORD_W-1:0] kept_x_ff [hplr_pkg::NUM_POINTS];
   logic [hplr_pkg::COORD_W-1:0] kept_x_in [hplr_pkg::NUM_POINTS];
   logic [hplr_pkg::COORD_W-1:0] kept_y_ff [hplr_pkg::NUM_POINTS];
   logic [hplr_pkg::COORD_W-1:0] kept_y_in [hplr_pkg::NUM_POINTS];
   logic [hplr_pkg::NUM_POINTS-1:0] seen_ff, seen_in;

   logic [hplr_pkg::PT_IDX_W-1:0]   pt_ff, pt_in;
   logic [hplr_pkg::SUM_W-1:0]      sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [hplr_pkg::COORD_W-1:0]    min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [hplr_pkg::SUM_W-1:0]      den_ff, den_in;
   logic [hplr_pkg::ELEM_IDX_W-1:0] elem_ff, elem_in;
   logic                            neg_ff, neg_in;
   logic                            ovf_ff, ovf_in;
   logic [hplr_pkg::SUM_W-1:0]      rem_ff, rem_in;
   logic [hplr_pkg::QUOT_W-1:0]     dvd_ff, dvd_in, quo_ff, quo_in;
   logic [hplr_pkg::STEP_W-1:0]     step_ff, step_in;
   logic signed [hplr_pkg::NORM_W-1:0] norm_ff, norm_in;
   logic [hplr_pkg::ANG_IDX_W-1:0]  ang_ff, ang_in;
   logic signed [hplr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [hplr_pkg::ACC_W-1:0]  acc_ff [hplr_pkg::ANGLES];
   logic signed [hplr_pkg::ACC_W-1:0]  acc_in [hplr_pkg::ANGLES];
   logic [hplr_pkg::STAT_W-1:0]     status_ff, status_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [hplr_pkg::ANGLE_W-1:0] pitch_ff, pitch_in, yaw_ff, yaw_in, roll_ff, roll_in;
   logic [hplr_pkg::STAT_W-1:0]         pstat_ff, pstat_in;

   // Combinational helpers
   logic [hplr_pkg::NUM_POINTS-1:0] hit;
   logic [hplr_pkg::NUM_POINTS-1:0] mask_now;
   logic                            in_range;
   logic [hplr_pkg::ELEM_IDX_W-1:0] elem_off;
   logic                            elem_is_y;
   logic [hplr_pkg::PT_IDX_W-1:0]   rd_slot;
   logic [hplr_pkg::COORD_W-1:0]    rd_x, rd_y, rd_p;
   logic [hplr_pkg::SUM_W-1:0]      scaled, sel_sum, mag, mag_hi;
   logic signed [hplr_pkg::NUMER_W-1:0] numer, numer_neg;
   logic [hplr_pkg::COORD_W-1:0]    spread;
   logic [hplr_pkg::SUM_W:0]        shifted;
   logic                            qbit;
   logic [hplr_pkg::QUOT_W:0]       q_round;
   logic [hplr_pkg::QUOT_W-1:0]     q_mag;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pose_status = pstat_ff;

   // Match the incoming landmark against the selection table
   always_comb begin
      in_range = {1'b0, req_landmark_number} < hplr_pkg::LM_CNT_W'(hplr_pkg::LANDMARK_COUNT);
      for (int j = 0; j < hplr_pkg::NUM_POINTS; j++) begin
         hit[j] = in_range && (req_landmark_number == hplr_pkg::SEL_INDEX[j]);
      end
      mask_now = seen_ff | hit;
   end

   // Single read port on the kept points: summing walks pt, division walks elem
   always_comb begin
      elem_off  = elem_ff - hplr_pkg::ELEM_IDX_W'(hplr_pkg::NUM_POINTS);
      elem_is_y = elem_ff >= hplr_pkg::ELEM_IDX_W'(hplr_pkg::NUM_POINTS);
      if (state_ff == ST_SUM) begin
         rd_slot = pt_ff;
      end else if (elem_is_y) begin
         rd_slot = elem_off[hplr_pkg::PT_IDX_W-1:0];
      end else begin
         rd_slot = elem_ff[hplr_pkg::PT_IDX_W-1:0];
      end
      rd_x = kept_x_ff[rd_slot];
      rd_y = kept_y_ff[rd_slot];
      rd_p    = elem_is_y ? rd_y : rd_x;
      sel_sum = elem_is_y ? sum_y_ff : sum_x_ff;
   end

   // Centred numerator, its magnitude, its high part for the divider's overflow check, and the y spread
   always_comb begin
      scaled    = hplr_pkg::SUM_W'(rd_p) * hplr_pkg::SUM_W'(hplr_pkg::NUM_POINTS);
      numer     = $signed({1'b0, scaled}) - $signed({1'b0, sel_sum});
      numer_neg = -numer;
      mag       = numer[hplr_pkg::NUMER_W-1] ? numer_neg[hplr_pkg::SUM_W-1:0]
                                             : numer[hplr_pkg::SUM_W-1:0];
      mag_hi    = mag >> hplr_pkg::HI_SHIFT;
      spread    = max_y_ff - min_y_ff;
   end

   // One restoring division step and the quotient rounding
   always_comb begin
      shifted = {rem_ff, dvd_ff[hplr_pkg::QUOT_W-1]};
      qbit    = shifted >= {1'b0, den_ff};
      q_round = {1'b0, quo_ff} + (hplr_pkg::QUOT_W+1)'(1);
      q_mag   = q_round[hplr_pkg::QUOT_W:1];
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      kept_x_in    = kept_x_ff;
      kept_y_in    = kept_y_ff;
      seen_in      = seen_ff;
      pt_in        = pt_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      den_in       = den_ff;
      elem_in      = elem_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      norm_in      = norm_ff;
      ang_in       = ang_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      roll_in      = roll_ff;
      pstat_in     = pstat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Store the point in its slot; on the last transfer close the frame
               for (int j = 0; j < hplr_pkg::NUM_POINTS; j++) begin
                  if (hit[j]) begin
                     kept_x_in[j] = req_coord_x;
                     kept_y_in[j] = req_coord_y;
                  end
               end
               seen_in = mask_now;
               if (req_last_landmark) begin
                  seen_in = '0;
                  if (mask_now != {hplr_pkg::NUM_POINTS{1'b1}}) begin
                     status_in = hplr_pkg::STATUS_MISSING;
                     for (int k = 0; k < hplr_pkg::ANGLES; k++) begin
                        acc_in[k] = '0;
                     end
                     state_in = ST_POST;
                  end else begin
                     pt_in    = '0;
                     sum_x_in = '0;
                     sum_y_in = '0;
                     min_y_in = '1;
                     max_y_in = '0;
                     state_in = ST_SUM;
                  end
               end
            end
         end

         ST_SUM: begin
            // Accumulate sums and the y extremes, one point a cycle
            sum_x_in = sum_x_ff + hplr_pkg::SUM_W'(rd_x);
            sum_y_in = sum_y_ff + hplr_pkg::SUM_W'(rd_y);
            if (rd_y < min_y_ff) begin
               min_y_in = rd_y;
            end
            if (rd_y > max_y_ff) begin
               max_y_in = rd_y;
            end
            if (pt_ff == hplr_pkg::PT_IDX_W'(hplr_pkg::NUM_POINTS - 1)) begin
               state_in = ST_SPREAD;
            end else begin
               pt_in = pt_ff + hplr_pkg::PT_IDX_W'(1);
            end
         end

         ST_SPREAD: begin
            for (int k = 0; k < hplr_pkg::ANGLES; k++) begin
               acc_in[k] = '0;
            end
            if (max_y_ff == min_y_ff) begin
               status_in = hplr_pkg::STATUS_FLAT;
               state_in  = ST_POST;
            end else begin
               den_in    = hplr_pkg::SUM_W'(spread) * hplr_pkg::SUM_W'(hplr_pkg::NUM_POINTS);
               status_in = hplr_pkg::STATUS_OK;
               elem_in   = '0;
               state_in  = ST_LOAD;
            end
         end

         ST_LOAD: begin
            ang_in = '0;
            if (elem_ff == hplr_pkg::ELEM_IDX_W'(hplr_pkg::ELEM_COUNT - 1)) begin
               // Bias term skips the divider
               norm_in  = hplr_pkg::ONE_Q16;
               state_in = ST_MUL;
            end else begin
               neg_in   = numer[hplr_pkg::NUMER_W-1];
               ovf_in   = mag_hi >= den_ff;
               rem_in   = (mag_hi >= den_ff) ? '0 : mag_hi;
               dvd_in   = {mag[hplr_pkg::HI_SHIFT-1:0], hplr_pkg::DVD_SHIFT'(0)};
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            // Shift in one dividend bit, subtract the divisor where it fits
            rem_in = qbit ? hplr_pkg::SUM_W'(shifted - {1'b0, den_ff})
                          : shifted[hplr_pkg::SUM_W-1:0];
            quo_in = {quo_ff[hplr_pkg::QUOT_W-2:0], qbit};
            dvd_in = dvd_ff << 1;
            if (step_ff == hplr_pkg::STEP_W'(hplr_pkg::QUOT_W - 1)) begin
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + hplr_pkg::STEP_W'(1);
            end
         end

         ST_ROUND: begin
            // Round half away from zero, then saturate to Q8.16
            if (neg_ff) begin
               if (ovf_ff || q_mag > hplr_pkg::QUOT_W'(1 << 23)) begin
                  norm_in = hplr_pkg::NORM_MIN;
               end else begin
                  norm_in = -$signed(q_mag[hplr_pkg::NORM_W-1:0]);
               end
            end else begin
               if (ovf_ff || q_mag > hplr_pkg::QUOT_W'((1 << 23) - 1)) begin
                  norm_in = hplr_pkg::NORM_MAX;
               end else begin
                  norm_in = $signed(q_mag[hplr_pkg::NORM_W-1:0]);
               end
            end
            state_in = ST_MUL;
         end

         ST_MUL: begin
            prod_in  = norm_ff * hplr_pkg::coefficient(elem_ff, ang_ff);
            state_in = ST_ACC;
         end

         ST_ACC: begin
            acc_in[ang_ff] = acc_ff[ang_ff] + hplr_pkg::ACC_W'(prod_ff);
            if (ang_ff == hplr_pkg::ANG_IDX_W'(hplr_pkg::ANGLES - 1)) begin
               if (elem_ff == hplr_pkg::ELEM_IDX_W'(hplr_pkg::ELEM_COUNT - 1)) begin
                  state_in = ST_POST;
               end else begin
                  elem_in  = elem_ff + hplr_pkg::ELEM_IDX_W'(1);
                  state_in = ST_LOAD;
               end
            end else begin
               ang_in   = ang_ff + hplr_pkg::ANG_IDX_W'(1);
               state_in = ST_MUL;
            end
         end

         ST_POST: begin
            // Hold until the result register is free, then load it
            if (!rsp_valid_ff || rsp_ready) begin
               pitch_in     = to_q8_8(acc_ff[0]);
               yaw_in       = to_q8_8(acc_ff[1]);
               roll_in      = to_q8_8(acc_ff[2]);
               pstat_in     = status_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kept_x_ff <= kept_x_in;
      kept_y_ff <= kept_y_in;
      pt_ff     <= pt_in;
      sum_x_ff  <= sum_x_in;
      sum_y_ff  <= sum_y_in;
      min_y_ff  <= min_y_in;
      max_y_ff  <= max_y_in;
      den_ff    <= den_in;
      elem_ff   <= elem_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      norm_ff   <= norm_in;
      ang_ff    <= ang_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      pitch_ff  <= pitch_in;
      yaw_ff    <= yaw_in;
      roll_ff   <= roll_in;
      pstat_ff  <= pstat_in;
   end

endmodule

FILE: src/hplr_checker.sv
// Port-level checks of the head pose regressor, bound to the top level.
module hplr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [hplr_pkg::NUM_W-1:0]           req_landmark_number,
   input logic [hplr_pkg::COORD_W-1:0]         req_coord_x,
   input logic [hplr_pkg::COORD_W-1:0]         req_coord_y,
   input logic                                 req_last_landmark,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [hplr_pkg::ANGLE_W-1:0]  rsp_pitch_angle,
   input logic signed [hplr_pkg::ANGLE_W-1:0]  rsp_yaw_angle,
   input logic signed [hplr_pkg::ANGLE_W-1:0]  rsp_roll_angle,
   input logic [hplr_pkg::STAT_W-1:0]          rsp_pose_status
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_angle)
         && $stable(rsp_yaw_angle) && $stable(rsp_roll_angle) && $stable(rsp_pose_status))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A failed frame carries zero angles
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pose_status != hplr_pkg::STATUS_OK |->
         rsp_pitch_angle == '0 && rsp_yaw_angle == '0 && rsp_roll_angle == '0)
      else $error("non-zero angles on a failed frame");

   // Status is a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pose_status == hplr_pkg::STATUS_OK
         || rsp_pose_status == hplr_pkg::STATUS_MISSING
         || rsp_pose_status == hplr_pkg::STATUS_FLAT)
      else $error("undefined pose status");

   // Closing a frame lowers input ready in the cycle after the transfer
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_landmark |=> !req_ready)
      else $error("input ready straight after the last landmark");

endmodule

bind head_pose_linear_regressor hplr_checker u_hplr_checker (.*);
